// File: hw/rtl/sbd_pkg.sv
// ----------------------------------------------------------------------------
// SPI baud divider search package
// Shared constants and types for the divider search unit and its helpers.
// ----------------------------------------------------------------------------
package sbd_pkg;

  // Default search limits
  localparam int COUNT_MAX_DEF    = 8;
  localparam int PRESCALE_MAX_DEF = 64;
  localparam int B_MAX_DEF        = 3;

  // Smallest bit-time count visited by the search
  localparam int CNT_MIN = 2;

  // Fixed field widths
  localparam int RATE_W  = 32;
  localparam int Q_W     = 7;
  localparam int FIELD_W = 6;
  localparam int ECON_W  = 27;
  localparam int RES_W   = 41;

  // Quanta frequency after reset
  localparam logic [RATE_W-1:0] QF_RESET = 32'd100000000;

  // Status of the shared divider
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// File: hw/rtl/sbd_div.sv
// ----------------------------------------------------------------------------
// SPI baud divider search: shared restoring divider
// Computes a Q_W-bit quotient one bit per cycle and flags a quotient that
// does not fit in Q_W bits.
// ----------------------------------------------------------------------------
module sbd_div #(
  parameter int N_W = 37
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [N_W-1:0]           num,
  input  logic [N_W-1:0]           den,
  output sbd_pkg::div_stat_t       stat,
  output logic [sbd_pkg::Q_W-1:0]  quo
);

  localparam int QW    = sbd_pkg::Q_W;
  localparam int DSH_W = N_W + QW - 1;
  localparam int STP_W = $clog2(QW);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dstate_t;

  dstate_t             state_r;
  logic [N_W-1:0]      rem_r;
  logic [DSH_W-1:0]    dsh_r;
  logic [STP_W-1:0]    step_r;
  logic [QW-1:0]       quo_r;
  logic                done_r;
  logic                ovf_r;
  logic                ovf_calc;
  logic                fits;

  // Quotient at least 2^QW when num >= den << QW
  assign ovf_calc = ({{QW{1'b0}}, num} >= {den, {QW{1'b0}}});
  // Shifted divisor fits under the running remainder
  assign fits     = ({{(QW-1){1'b0}}, rem_r} >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      ovf_r   <= 1'b0;
      step_r  <= '0;
      quo_r   <= '0;
      rem_r   <= '0;
      dsh_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          // Load operands and take the range check
          if (start) begin
            rem_r   <= num;
            dsh_r   <= {den, {(QW-1){1'b0}}};
            ovf_r   <= ovf_calc;
            quo_r   <= '0;
            step_r  <= STP_W'(QW - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          // Subtract and shift, one quotient bit per cycle
          if (fits) begin
            rem_r <= rem_r - dsh_r[N_W-1:0];
          end
          quo_r <= {quo_r[QW-2:0], fits};
          dsh_r <= dsh_r >> 1;
          if (step_r == '0) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign quo       = quo_r;

endmodule

// File: hw/rtl/spi_baud_divider_search_unit.sv
// ----------------------------------------------------------------------------
// SPI baud divider search unit
// Picks bit-time count and prescaler for a requested baud rate and packs the
// extended configuration word.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_wr_en with cfg_wr_data writes the time-quanta
//   frequency; write it only while the unit is idle.
//   Input: in_valid with in_baud_rate and in_parity_enable; a transaction
//   completes when in_valid is high and in_stall is low. in_stall stays high
//   while a search runs.
//   Output: out_valid with the packed word, prescaler, bit-time count and
//   residual error; a transaction completes when out_valid is high and
//   out_stall is low. A held result stays stable until taken.
//   Search: each bit-time count runs through the shared divider, which
//   produces one quotient bit per cycle (7 bits). A full search visits
//   counts COUNT_MAX down to 2; an exact even count ends the search early.
//   Throughput: one transaction per search; the next input is taken while a
//   result still waits in the output register.
//   Reset: quanta frequency returns to 100 MHz, no result is pending.
// ----------------------------------------------------------------------------
module spi_baud_divider_search_unit #(
  parameter int COUNT_MAX    = sbd_pkg::COUNT_MAX_DEF,
  parameter int PRESCALE_MAX = sbd_pkg::PRESCALE_MAX_DEF,
  parameter int B_MAX        = sbd_pkg::B_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [sbd_pkg::RATE_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sbd_pkg::RATE_W-1:0]   in_baud_rate,
  input  logic                         in_parity_enable,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sbd_pkg::ECON_W-1:0]   out_econ_word,
  output logic [sbd_pkg::Q_W-1:0]      out_prescale_count,
  output logic [sbd_pkg::Q_W-1:0]      out_bit_time_count,
  output logic [sbd_pkg::RES_W-1:0]    out_residual_error
);

  localparam int RW    = sbd_pkg::RATE_W;
  localparam int QW    = sbd_pkg::Q_W;
  localparam int FW    = sbd_pkg::FIELD_W;
  localparam int CNT_W = $clog2(COUNT_MAX + 1);
  localparam int DEN_W = RW + CNT_W;
  localparam int N_W   = DEN_W + 1;
  localparam int PRD_W = DEN_W + QW;
  localparam int QC_W  = QW + CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEN,
    S_START,
    S_WAIT,
    S_MUL,
    S_CMP,
    S_OUT
  } state_t;

  // Control state
  state_t               state_r,     state_nxt;
  logic [RW-1:0]        qf_r,        qf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 have_r,      have_nxt;
  // Working payload
  logic [RW-1:0]        baud_r,      baud_nxt;
  logic                 par_r,       par_nxt;
  logic [CNT_W-1:0]     cnt_r,       cnt_nxt;
  logic [DEN_W-1:0]     den_r,       den_nxt;
  logic [QW-1:0]        q_r,         q_nxt;
  logic [PRD_W-1:0]     prod_r,      prod_nxt;
  logic [PRD_W-1:0]     best_err_r,  best_err_nxt;
  logic [CNT_W-1:0]     best_cnt_r,  best_cnt_nxt;
  logic [QW-1:0]        best_q_r,    best_q_nxt;
  // Result registers
  logic [sbd_pkg::ECON_W-1:0] econ_r,  econ_nxt;
  logic [QW-1:0]              oq_r,    oq_nxt;
  logic [QW-1:0]              ocnt_r,  ocnt_nxt;
  logic [sbd_pkg::RES_W-1:0]  oerr_r,  oerr_nxt;

  // Datapath
  logic                 div_start;
  logic [N_W-1:0]       div_num;
  logic [N_W-1:0]       div_den;
  sbd_pkg::div_stat_t   div_stat;
  logic [QW-1:0]        div_quo;
  logic [DEN_W-1:0]     den_calc;
  logic [QC_W-1:0]      qc_calc;
  logic [QW-1:0]        q_clamp;
  logic [PRD_W-1:0]     prod_calc;
  logic [PRD_W-1:0]     fq_ext;
  logic [PRD_W-1:0]     err_calc;
  logic                 take;
  logic                 stop;
  logic [CNT_W-1:0]     new_cnt;
  logic                 swap;
  logic [QW-1:0]        fin_q;
  logic [QW-1:0]        fin_cnt;
  logic [QW-1:0]        half;
  logic                 d_pos;
  logic [FW-1:0]        a_f;
  logic [FW-1:0]        b_f;
  logic [FW-1:0]        c_f;
  logic [FW-1:0]        qm1_f;

  // Shared divider: q = (2*fq + den) / (2*den)
  assign div_start = (state_r == S_START);
  assign div_num   = N_W'({qf_r, 1'b0}) + N_W'(den_r);
  assign div_den   = {den_r, 1'b0};

  sbd_div #(
    .N_W (N_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // Scaled period for this count
  assign den_calc = DEN_W'(cnt_r) * DEN_W'(baud_r);

  // Clamp the prescaler: cap at the maximum, raise it to 2 when its product with the count is below 4
  assign qc_calc = QC_W'(div_quo) * QC_W'(cnt_r);
  always_comb begin
    if (div_stat.ovf || (div_quo > QW'(PRESCALE_MAX))) begin
      q_clamp = QW'(PRESCALE_MAX);
    end else if (qc_calc < QC_W'(4)) begin
      q_clamp = QW'(2);
    end else begin
      q_clamp = div_quo;
    end
  end

  // Error of the candidate
  assign prod_calc = PRD_W'(den_r) * PRD_W'(q_r);
  assign fq_ext    = PRD_W'(qf_r);
  assign err_calc  = (prod_r >= fq_ext) ? (prod_r - fq_ext) : (fq_ext - prod_r);

  // On a tie an odd best count stays and an even one is replaced; stop on an exact even count
  assign take    = !have_r || (err_calc < best_err_r) ||
                   ((err_calc == best_err_r) && !best_cnt_r[0]);
  assign new_cnt = take ? cnt_r : best_cnt_r;
  assign stop    = (have_r ? (err_calc <= best_err_r) : 1'b1) &&
                   !new_cnt[0] && (err_calc == '0);

  // Swap an odd count with an even small prescaler
  assign swap    = (best_q_r <= QW'(COUNT_MAX)) && best_cnt_r[0] && !best_q_r[0];
  assign fin_q   = swap ? QW'(best_cnt_r) : best_q_r;
  assign fin_cnt = swap ? best_q_r : QW'(best_cnt_r);

  // Split the count into A, B and C segments
  assign half  = fin_cnt >> 1;
  assign d_pos = (half > QW'(B_MAX));
  assign a_f   = FW'(half + QW'(fin_cnt[0]) - QW'(1));
  assign c_f   = d_pos ? FW'(half - QW'(B_MAX)) : '0;
  assign b_f   = d_pos ? FW'(B_MAX) : FW'(half);
  assign qm1_f = FW'(fin_q - QW'(1));

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    qf_nxt        = qf_r;
    out_valid_nxt = out_valid_r;
    have_nxt      = have_r;
    baud_nxt      = baud_r;
    par_nxt       = par_r;
    cnt_nxt       = cnt_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    prod_nxt      = prod_r;
    best_err_nxt  = best_err_r;
    best_cnt_nxt  = best_cnt_r;
    best_q_nxt    = best_q_r;
    econ_nxt      = econ_r;
    oq_nxt        = oq_r;
    ocnt_nxt      = ocnt_r;
    oerr_nxt      = oerr_r;

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration write
    if (cfg_wr_en) begin
      qf_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          baud_nxt  = (in_baud_rate == '0) ? RW'(1) : in_baud_rate;
          par_nxt   = in_parity_enable;
          cnt_nxt   = CNT_W'(COUNT_MAX);
          have_nxt  = 1'b0;
          state_nxt = S_DEN;
        end
      end
      S_DEN: begin
        den_nxt   = den_calc;
        state_nxt = S_START;
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_stat.done) begin
          q_nxt     = q_clamp;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = prod_calc;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (take) begin
          best_err_nxt = err_calc;
          best_cnt_nxt = cnt_r;
          best_q_nxt   = q_r;
          have_nxt     = 1'b1;
        end
        if (stop || (cnt_r == CNT_W'(sbd_pkg::CNT_MIN))) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DEN;
        end
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          econ_nxt      = {par_r, 2'b00, b_f, c_f, a_f, qm1_f};
          oq_nxt        = fin_q;
          ocnt_nxt      = fin_cnt;
          oerr_nxt      = best_err_r[sbd_pkg::RES_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    baud_r     <= baud_nxt;
    par_r      <= par_nxt;
    cnt_r      <= cnt_nxt;
    den_r      <= den_nxt;
    q_r        <= q_nxt;
    prod_r     <= prod_nxt;
    best_err_r <= best_err_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_q_r   <= best_q_nxt;
    econ_r     <= econ_nxt;
    oq_r       <= oq_nxt;
    ocnt_r     <= ocnt_nxt;
    oerr_r     <= oerr_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qf_r        <= sbd_pkg::QF_RESET;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qf_r        <= qf_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_econ_word      = econ_r;
  assign out_prescale_count = oq_r;
  assign out_bit_time_count = ocnt_r;
  assign out_residual_error = oerr_r;

endmodule

// File: hw/rtl/sbd_checker.sv
// ----------------------------------------------------------------------------
// SPI baud divider search checker
// Port-level checks on the search unit, attached by bind.
// ----------------------------------------------------------------------------
module sbd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [sbd_pkg::ECON_W-1:0]   out_econ_word,
  input logic [sbd_pkg::Q_W-1:0]      out_prescale_count,
  input logic [sbd_pkg::Q_W-1:0]      out_bit_time_count,
  input logic [sbd_pkg::RES_W-1:0]    out_residual_error
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_econ_word) &&
      $stable(out_residual_error))
    else $error("stalled result changed");

  // An accepted transaction starts a search that blocks new input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while search runs");

  // Result fields in range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bit_time_count >= 7'd2) && (out_prescale_count != 7'd0))
    else $error("result count or prescaler out of range");

  // Packed word agrees with the prescaler and leaves phase bits clear
  a_out_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_econ_word[5:0] == 6'(out_prescale_count - 7'd1)) &&
      (out_econ_word[25:24] == 2'b00))
    else $error("packed word mismatch");

endmodule

bind spi_baud_divider_search_unit sbd_checker u_sbd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_econ_word      (out_econ_word),
  .out_prescale_count (out_prescale_count),
  .out_bit_time_count (out_bit_time_count),
  .out_residual_error (out_residual_error)
);

// File: tb/spi_baud_divider_search_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI baud divider search unit testbench
// Drives baud-rate requests through the valid/stall input channel under
// several time-quanta settings and checks every packed result against an
// in-bench model of the count/prescaler search, with random idle on both
// sides, one long receiver hold-off and one sender pause.
// ----------------------------------------------------------------------------
module spi_baud_divider_search_unit_tb;

  localparam int RATE_W       = sbd_pkg::RATE_W;
  localparam int Q_W          = sbd_pkg::Q_W;
  localparam int FIELD_W      = sbd_pkg::FIELD_W;
  localparam int ECON_W       = sbd_pkg::ECON_W;
  localparam int RES_W        = sbd_pkg::RES_W;
  localparam int SEARCH_TOP   = sbd_pkg::COUNT_MAX_DEF;
  localparam int PRESCALE_TOP = sbd_pkg::PRESCALE_MAX_DEF;
  localparam int B_TOP        = sbd_pkg::B_MAX_DEF;
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [RATE_W-1:0] baud;
    logic              parity;
  } rate_request_t;

  typedef struct packed {
    logic [ECON_W-1:0] econ;
    logic [Q_W-1:0]    q;
    logic [Q_W-1:0]    cnt;
    logic [RES_W-1:0]  err;
  } divider_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [RATE_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [RATE_W-1:0] in_baud_rate = '0;
  logic              in_parity_enable = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ECON_W-1:0] out_econ_word;
  logic [Q_W-1:0]    out_prescale_count;
  logic [Q_W-1:0]    out_bit_time_count;
  logic [RES_W-1:0]  out_residual_error;

  rate_request_t     rate_requests[$];
  divider_result_t   divider_results_due[$];
  logic [RATE_W-1:0] quanta_hz = sbd_pkg::QF_RESET;
  logic              in_taken = 1'b0;
  bit                quiet = 1'b0;
  int                send_gap = 0;
  int                recv_gap = 0;
  int                hold_left = 0;
  int                hold_reqs = 0;
  int                holds_done = 0;
  int                errors = 0;
  int                requests_sent = 0;
  int                results_checked = 0;
  int                settings_used = 1;
  int                idle_cycles = 0;

  spi_baud_divider_search_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_baud_rate      (in_baud_rate),
    .in_parity_enable  (in_parity_enable),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_econ_word     (out_econ_word),
    .out_prescale_count(out_prescale_count),
    .out_bit_time_count(out_bit_time_count),
    .out_residual_error(out_residual_error)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Search counts from the top down, keep the best error, swap odd count
  // with even prescaler, then pack the configuration word
  function automatic divider_result_t search_divider(input logic [RATE_W-1:0] baud_in,
                                                     input logic par,
                                                     input logic [RATE_W-1:0] fq_in);
    logic [63:0] baud, fq, den, q, err, prod;
    logic [63:0] best_err, best_cnt, best_q, swap_tmp, half;
    logic [FIELD_W-1:0] a_f, b_f, c_f;
    bit have, done;
    int cnt;
    divider_result_t r;
    baud = (baud_in == '0) ? 64'd1 : 64'(baud_in);
    fq = 64'(fq_in);
    best_err = 0;
    best_cnt = SEARCH_TOP;
    best_q = 1;
    have = 1'b0;
    done = 1'b0;
    for (cnt = SEARCH_TOP; cnt >= sbd_pkg::CNT_MIN && !done; cnt--) begin
      den = 64'(cnt) * baud;
      q = (2 * fq + den) / (2 * den);
      if (q > PRESCALE_TOP) begin
        q = PRESCALE_TOP;
      end else if (q * 64'(cnt) < 4) begin
        q = 2;
      end
      prod = den * q;
      err = (prod >= fq) ? prod - fq : fq - prod;
      if (!have || err <= best_err) begin
        // Equal error replaces only an even best count
        if (!have || err != best_err || !best_cnt[0]) begin
          best_err = err;
          best_cnt = cnt;
          best_q = q;
          have = 1'b1;
        end
        if (!best_cnt[0] && err == 0) begin
          done = 1'b1;
        end
      end
    end
    if (best_q <= SEARCH_TOP && best_cnt[0] && !best_q[0]) begin
      swap_tmp = best_q;
      best_q = best_cnt;
      best_cnt = swap_tmp;
    end
    half = best_cnt >> 1;
    a_f = FIELD_W'(half + best_cnt[0] - 1);
    if (half > B_TOP) begin
      c_f = FIELD_W'(half - B_TOP);
      b_f = FIELD_W'(B_TOP);
    end else begin
      c_f = '0;
      b_f = FIELD_W'(half);
    end
    r.econ = {par, 2'b00, b_f, c_f, a_f, FIELD_W'(best_q - 1)};
    r.q = Q_W'(best_q);
    r.cnt = Q_W'(best_cnt);
    r.err = RES_W'(best_err);
    return r;
  endfunction

  // Mostly rates aimed at a count*prescaler product, with noise mixed in
  function automatic rate_request_t random_request();
    rate_request_t req;
    logic [63:0] base;
    int pick;
    pick = $urandom_range(0, 99);
    req.parity = 1'($urandom_range(0, 1));
    if (pick < 60) begin
      base = 64'(quanta_hz) / 64'($urandom_range(2, 8) * $urandom_range(1, 64));
      case ($urandom_range(0, 3))
        0: base = base + 1;
        1: base = (base > 0) ? base - 1 : base;
        2: base = base + 64'($urandom_range(0, 50));
        default: ;
      endcase
      if (base == 0) begin
        base = 64'($urandom_range(1, 16));
      end
      req.baud = RATE_W'(base);
    end else if (pick < 75) begin
      req.baud = $urandom();
    end else if (pick < 90) begin
      req.baud = $urandom_range(0, 2000);
    end else begin
      req.baud = $urandom_range(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    end
    return req;
  endfunction

  task automatic load_random(input int n);
    for (int i = 0; i < n; i++) begin
      rate_requests.push_back(random_request());
    end
  endtask

  task automatic push_rate(input logic [RATE_W-1:0] baud, input logic par);
    rate_request_t req;
    req.baud = baud;
    req.parity = par;
    rate_requests.push_back(req);
  endtask

  // Hold until every request is taken and every result has come back
  task automatic wait_idle();
    @(posedge clk);
    while (rate_requests.size() != 0 || in_valid || divider_results_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_quanta(input logic [RATE_W-1:0] hz);
    wait_idle();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= hz;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Drive requests at the falling edge; hold the payload until taken
  always @(negedge clk) begin : drive_requests
    logic next_valid;
    rate_request_t req;
    next_valid = in_valid && !in_taken;
    if (rst_n) begin
      if (in_valid && in_taken && !quiet && $urandom_range(0, 3) == 0) begin
        send_gap = $urandom_range(1, 6);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (rate_requests.size() != 0) begin
          req = rate_requests.pop_front();
          in_baud_rate <= req.baud;
          in_parity_enable <= req.parity;
          next_valid = 1'b1;
        end
      end
    end
    in_valid <= next_valid;
  end

  // Receiver stall: one long hold-off on request, otherwise short bursts
  always @(negedge clk) begin : drive_stall
    logic stall;
    stall = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      stall = 1'b1;
    end else if (holds_done != hold_reqs) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      stall = 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      stall = 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      recv_gap = $urandom_range(0, 5);
      stall = 1'b1;
    end
    out_stall <= stall;
  end

  // Track the register, predict on each input transaction, check each result
  always @(posedge clk) begin : monitor
    divider_result_t want;
    in_taken <= in_valid && !in_stall && rst_n;
    if (rst_n) begin
      if (cfg_wr_en) begin
        quanta_hz <= cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        divider_results_due.push_back(search_divider(in_baud_rate, in_parity_enable, quanta_hz));
        requests_sent++;
      end
      if (out_valid && !out_stall) begin
        if (divider_results_due.size() == 0) begin
          $display("%0t: result with none expected, actual word %0h q %0d count %0d",
                   $time, out_econ_word, out_prescale_count, out_bit_time_count);
          errors++;
        end else begin
          want = divider_results_due.pop_front();
          check_field("econ_word", want.econ, out_econ_word);
          check_field("prescale_count", want.q, out_prescale_count);
          check_field("bit_time_count", want.cnt, out_bit_time_count);
          check_field("residual_error", want.err, out_residual_error);
        end
        results_checked++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("spi_baud_divider_search_unit_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [RATE_W-1:0] rand_hz;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero and extreme rates, exact stop, ties, swap, clamps
    push_rate(32'd0, 1'b0);
    push_rate(32'd0, 1'b1);
    push_rate(32'd1, 1'b1);
    push_rate(32'hFFFF_FFFF, 1'b1);
    push_rate(32'h8000_0000, 1'b0);
    push_rate(32'd1562500, 1'b0);
    push_rate(32'd4166667, 1'b1);
    push_rate(32'd10000000, 1'b0);
    push_rate(32'd12500000, 1'b1);
    push_rate(32'd25000000, 1'b0);
    push_rate(32'd50000000, 1'b1);
    push_rate(32'd1000000, 1'b0);
    push_rate(32'd115200, 1'b1);
    push_rate(32'd3, 1'b0);
    push_rate(32'h5555_5555, 1'b1);
    push_rate(32'hAAAA_AAAA, 1'b0);
    push_rate(32'd33333333, 1'b1);
    push_rate(32'd6250000, 1'b0);
    push_rate(32'd781250, 1'b1);
    push_rate(32'd1562499, 1'b0);
    load_random(130);
    // Long receiver hold-off while the sender keeps offering
    hold_reqs++;
    wait_idle();

    set_quanta(32'd1);
    load_random(100);
    set_quanta(32'hFFFF_FFFF);
    load_random(80);
    // Sender pause until every result is back
    wait_idle();
    load_random(80);
    set_quanta(32'd100000000);
    load_random(160);
    rand_hz = $urandom();
    set_quanta((rand_hz == '0) ? 32'd1 : rand_hz);
    load_random(160);
    set_quanta(32'd48000000);
    load_random(160);
    rand_hz = $urandom();
    set_quanta((rand_hz == '0) ? 32'd1 : rand_hz);
    // Final stretch runs without idling
    quiet = 1'b1;
    load_random(160);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (divider_results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, divider_results_due.size());
      errors++;
    end
    $display("covered %0d rate requests and %0d checked results over %0d quanta settings",
             requests_sent, results_checked, settings_used);
    if (errors == 0) begin
      $display("spi_baud_divider_search_unit_tb: clean");
    end else begin
      $display("spi_baud_divider_search_unit_tb: errors");
    end
    $finish;
  end

endmodule
